FILE: rtl/core/rgct_pkg.sv
// shared types and constants for the 3-d grid cell traversal core
// no dependencies; imported by every module of the core
`default_nettype none

package rgct_pkg;

  localparam int MAX_CELLS = 64;
  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  localparam int ORG_W = 32;
  localparam int DIR_W = 16;
  localparam int MD_W = 31;
  localparam int SIZE_W = 29;
  localparam int CELL_W = 17;
  localparam int FRAC_W = 15;
  localparam int DVD_W = SIZE_W + FRAC_W;
  localparam int T_W = DVD_W + CNT_W;

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(65536);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(268435456);
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(1048576);

  // setup division sequence
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_FX = 4'd0;
  localparam logic [OP_W-1:0] OP_FY = 4'd1;
  localparam logic [OP_W-1:0] OP_FZ = 4'd2;
  localparam logic [OP_W-1:0] OP_MD = 4'd3;
  localparam logic [OP_W-1:0] OP_TMX = 4'd4;
  localparam logic [OP_W-1:0] OP_TMY = 4'd5;
  localparam logic [OP_W-1:0] OP_TMZ = 4'd6;
  localparam logic [OP_W-1:0] OP_TDX = 4'd7;
  localparam logic [OP_W-1:0] OP_TDY = 4'd8;
  localparam logic [OP_W-1:0] OP_TDZ = 4'd9;
  localparam logic [OP_W-1:0] OP_LAST = OP_TDZ;

  typedef struct packed {
    logic            load_ray;
    logic            start_div;
    logic            capture;
    logic [OP_W-1:0] op;
    logic            walk;
  } rgct_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
  } rgct_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/rgct_div.sv
// restoring unsigned divider, one quotient bit per cycle
// uses rgct_pkg widths
`default_nettype none

module rgct_div
  import rgct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [SIZE_W-1:0] divisor,
  output logic [DVD_W-1:0]       quotient,
  output logic [SIZE_W-1:0]      remainder,
  output logic                   done
);

  localparam int DC_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dsr;
  logic [DC_W-1:0]   cnt;
  logic              busy;
  logic [SIZE_W:0]   sh;
  logic              fit;

  assign sh = {rem, dvd[DVD_W-1]};
  assign fit = sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= DC_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], fit};
      rem <= fit ? SIZE_W'(sh - {1'b0, dsr}) : sh[SIZE_W-1:0];
    end
  end

  assign quotient = dvd;
  assign remainder = rem;

endmodule

`default_nettype wire

FILE: rtl/core/rgct_ctrl.sv
// controller: ray setup division sequence, then the cell walk
// uses rgct_pkg command and status types
`default_nettype none

module rgct_ctrl
  import rgct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  rgct_sts_t sts,
  output rgct_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_WALK  = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [OP_W-1:0] op, op_next;

  always_comb begin
    state_next = state;
    op_next = op;
    cmd = '0;
    cmd.op = op;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_ray = 1'b1;
          op_next = OP_FX;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.start_div = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.div_done) begin
          cmd.capture = 1'b1;
          if (op == OP_LAST) begin
            state_next = ST_WALK;
          end else begin
            op_next = op + 1'b1;
            state_next = ST_START;
          end
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= OP_FX;
    end else begin
      state <= state_next;
      op <= op_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rgct_dp.sv
// datapath: ray registers, setup operand mux, dda walk and output word register
// uses rgct_pkg, instantiates rgct_div
`default_nettype none

module rgct_dp
  import rgct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  rgct_cmd_t              cmd,
  output rgct_sts_t              sts,
  input  wire logic [SIZE_W-1:0] size,
  input  wire logic [ORG_W-1:0]  origin_x,
  input  wire logic [ORG_W-1:0]  origin_y,
  input  wire logic [ORG_W-1:0]  origin_z,
  input  wire logic [DIR_W-1:0]  dir_x,
  input  wire logic [DIR_W-1:0]  dir_y,
  input  wire logic [DIR_W-1:0]  dir_z,
  input  wire logic [MD_W-1:0]   max_distance,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CELL_W-1:0]      cell_x,
  output logic [CELL_W-1:0]      cell_y,
  output logic [CELL_W-1:0]      cell_z,
  output logic                   last
);

  logic [ORG_W-1:0]  org [3];
  logic [DIR_W-1:0]  dir [3];
  logic [MD_W-1:0]   md;
  logic [CELL_W-1:0] cidx [3];
  logic [SIZE_W-1:0] rem [3];
  logic [T_W-1:0]    tmax [3];
  logic [DVD_W-1:0]  tdel [3];
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  n;
  logic [2:0]        mv;

  logic [DVD_W-1:0]  dvd;
  logic [SIZE_W-1:0] dsr;
  logic [DVD_W-1:0]  quo;
  logic [SIZE_W-1:0] rmd;
  logic              div_done;
  logic [1:0]        ax;
  logic [ORG_W-1:0]  org_abs;
  logic [DIR_W-1:0]  mag;
  logic [SIZE_W-1:0] diff;

  always_comb begin
    ax = 2'd0;
    unique case (cmd.op)
      OP_FY, OP_TMY, OP_TDY: ax = 2'd1;
      OP_FZ, OP_TMZ, OP_TDZ: ax = 2'd2;
      default: ax = 2'd0;
    endcase
  end

  assign org_abs = org[ax][ORG_W-1] ? (~org[ax] + 1'b1) : org[ax];
  assign mag = dir[ax][DIR_W-1] ? (~dir[ax] + 1'b1) : dir[ax];
  assign diff = dir[ax][DIR_W-1] ? rem[ax] : (size - rem[ax]);

  always_comb begin
    dvd = DVD_W'(org_abs);
    dsr = size;
    unique case (cmd.op)
      OP_FX, OP_FY, OP_FZ: dvd = DVD_W'(org_abs);
      OP_MD: dvd = DVD_W'(md);
      OP_TMX, OP_TMY, OP_TMZ: begin
        dvd = {diff, FRAC_W'(0)};
        dsr = SIZE_W'(mag);
      end
      OP_TDX, OP_TDY, OP_TDZ: begin
        dvd = {size, FRAC_W'(0)};
        dsr = SIZE_W'(mag);
      end
      default: dvd = DVD_W'(org_abs);
    endcase
  end

  rgct_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start_div),
    .dividend  (dvd),
    .divisor   (dsr),
    .quotient  (quo),
    .remainder (rmd),
    .done      (div_done)
  );

  // axis selection, ties to y then z
  logic       e01, e02, e12;
  logic [1:0] a;
  logic       stop;
  logic       step;

  assign e01 = mv[0] && (!mv[1] || tmax[0] < tmax[1]);
  assign e02 = mv[0] && (!mv[2] || tmax[0] < tmax[2]);
  assign e12 = mv[1] && (!mv[2] || tmax[1] < tmax[2]);

  always_comb begin
    priority if (e01 && e02) a = 2'd0;
    else if (e12) a = 2'd1;
    else a = 2'd2;
  end

  assign stop = !mv[a] || (tmax[a] > T_W'(md)) || ((n + 1'b1) >= limit);
  assign step = cmd.walk && (!out_valid || out_ready);
  assign sts = '{div_done: div_done, walk_done: (step && stop)};

  always_ff @(posedge clk) begin
    if (cmd.load_ray) begin
      org[0] <= origin_x;
      org[1] <= origin_y;
      org[2] <= origin_z;
      dir[0] <= dir_x;
      dir[1] <= dir_y;
      dir[2] <= dir_z;
      md <= max_distance;
      n <= '0;
    end
    if (cmd.capture) begin
      unique case (cmd.op)
        OP_FX, OP_FY, OP_FZ: begin
          if (!org[ax][ORG_W-1]) begin
            cidx[ax] <= quo[CELL_W-1:0];
            rem[ax] <= rmd;
          end else if (rmd == '0) begin
            cidx[ax] <= ~quo[CELL_W-1:0] + 1'b1;
            rem[ax] <= '0;
          end else begin
            cidx[ax] <= ~quo[CELL_W-1:0];
            rem[ax] <= size - rmd;
          end
        end
        OP_MD: begin
          if (quo > DVD_W'(MAX_CELLS - 3)) limit <= CNT_W'(MAX_CELLS);
          else limit <= CNT_W'(quo) + CNT_W'(3);
        end
        OP_TMX, OP_TMY, OP_TMZ: tmax[ax] <= T_W'(quo);
        OP_TDX, OP_TDY, OP_TDZ: tdel[ax] <= quo;
        default: ;
      endcase
    end
    if (step) begin
      cell_x <= cidx[0];
      cell_y <= cidx[1];
      cell_z <= cidx[2];
      last <= stop;
      n <= n + 1'b1;
      if (mv[a]) begin
        cidx[a] <= dir[a][DIR_W-1] ? (cidx[a] - 1'b1) : (cidx[a] + 1'b1);
        tmax[a] <= tmax[a] + T_W'(tdel[a]);
      end
    end
  end

  always_comb begin
    mv[0] = dir[0] != '0;
    mv[1] = dir[1] != '0;
    mv[2] = dir[2] != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ray_grid_cell_traversal_3d_core.sv
// top level of the 3-d grid cell traversal core
// uses rgct_pkg, instantiates rgct_ctrl and rgct_dp
`default_nettype none

// Takes one ray per input word and emits the grid cells it crosses, one output
// word per cell, last set on the final one. A ray is set up with ten serial
// divisions on one shared one-bit-per-cycle divider (three cell floors, the
// distance limit, three first crossings, three per-cell increments); the walk
// then emits one cell per cycle while the output is taken. A ray yields at most
// 64 cells. A new ray is taken once the last cell is in the output register.
// cell_size is written through the cfg channel; the user must write it only
// while idle, as the block itself does not enforce this. Values outside
// 65536..268435456 are clamped.
module ray_grid_cell_traversal_3d_core
  import rgct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ORG_W-1:0]  origin_x,
  input  wire logic [ORG_W-1:0]  origin_y,
  input  wire logic [ORG_W-1:0]  origin_z,
  input  wire logic [DIR_W-1:0]  dir_x,
  input  wire logic [DIR_W-1:0]  dir_y,
  input  wire logic [DIR_W-1:0]  dir_z,
  input  wire logic [MD_W-1:0]   max_distance,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CELL_W-1:0]      cell_x,
  output logic [CELL_W-1:0]      cell_y,
  output logic [CELL_W-1:0]      cell_z,
  output logic                   last
);

  logic [SIZE_W-1:0] cell_size;
  logic [SIZE_W-1:0] size;
  rgct_cmd_t         cmd;
  rgct_sts_t         sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= SIZE_RST;
    end else if (cfg_valid) begin
      cell_size <= cfg_data;
    end
  end

  assign size = (cell_size < SIZE_MIN) ? SIZE_MIN :
                (cell_size > SIZE_MAX) ? SIZE_MAX : cell_size;

  rgct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rgct_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .size         (size),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .origin_z     (origin_z),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .dir_z        (dir_z),
    .max_distance (max_distance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_z       (cell_z),
    .last         (last)
  );

endmodule

`default_nettype wire
